// ===== src/sign_split_dual_stack_unit_defines.svh =====
// Assertion macros shared by the stack unit RTL.
// Both expand to nothing when SYNTHESIS is defined.
`ifndef SIGN_SPLIT_DUAL_STACK_UNIT_DEFINES_SVH
`define SIGN_SPLIT_DUAL_STACK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define SSDS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssds assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssds assertion failed");

`else

`define SSDS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SSDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/ssds_pkg.sv =====
`timescale 1ns / 1ps

package ssds_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 7;
    localparam int CMD_W  = 3;
    localparam int KIND_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_NEG  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_POS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST_POS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST_NEG = 3'd4;

    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

    localparam logic       CFG_POS_CAP = 1'b0;
    localparam logic       CFG_NEG_CAP = 1'b1;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [DATA_W-1:0] VAL_ALL_ONES = '1;
    localparam logic [DATA_W-1:0] VAL_ZERO     = '0;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [KIND_W-1:0]        result_kind;
        logic                     last;
    } t_out_item;

    // Per-cycle control shared by every cell of one chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic rot;
    } t_cell_ctl;

endpackage

// ===== src/sign_split_dual_stack_unit.sv =====
// Two LIFO stacks of signed 32-bit words, split by the sign of the pushed value.
// Input channel: i_in_valid / o_in_stall carry one t_in_item (cmd, value) per
// transaction. Result channel: o_out_valid / i_out_stall carry t_out_item
// (result_value, result_kind, last); a transaction completes when valid is high
// and stall is low. Configuration: i_cfg_valid / o_cfg_ready write a capacity
// register (index 0 positive stack, index 1 negative stack); ready is always high.
// Each stack is a row of cells with the top entry in cell 0, so push and pop
// shift every entry of the row by one place at once.
// A pop, refused push, empty case or invalid command shows its result in the
// output register in the cycle after the transaction is accepted. A good
// push produces no result and does not itself stall the input.
// A listing of N entries rotates the row N times, one result per cycle, and the
// input is stalled until its last result is loaded (fewer results per cycle when stalled).
// Throughput is one command per cycle for push and pop while the output is not stalled.
// Reset (synchronous, active low) empties both stacks, sets both capacities to
// 64 and drops the output valid; stack contents are not cleared.
// When the receiver stalls, the result stays in the output register unchanged and
// the input is stalled until that register can take a new result.
`timescale 1ns / 1ps
`include "sign_split_dual_stack_unit_defines.svh"

module sign_split_dual_stack_unit
    import ssds_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    localparam logic SEL_POS = 1'b0;
    localparam logic SEL_NEG = 1'b1;

    logic             r_state,   n_state;
    logic             r_sel,     n_sel;
    logic [CNT_W-1:0] r_left,    n_left;
    logic [CNT_W-1:0] r_pos_cnt, n_pos_cnt;
    logic [CNT_W-1:0] r_neg_cnt, n_neg_cnt;
    logic [CAP_W-1:0] r_pos_cap;
    logic [CAP_W-1:0] r_neg_cap;
    logic             r_out_valid;
    t_out_item        r_out,     n_out;

    logic              out_free;
    logic              in_acc;
    logic              out_load;
    logic              pos_full;
    logic              neg_full;
    logic              pos_empty;
    logic              neg_empty;
    t_cell_ctl         pos_ctl;
    t_cell_ctl         neg_ctl;
    logic [DATA_W-1:0] pos_top;
    logic [DATA_W-1:0] neg_top;

    // The output register can take a new result when it is empty or draining.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // A stack is full at its capacity register or at the physical depth,
    // whichever is lower.
    assign pos_full  = (CAP_W'(r_pos_cnt) >= r_pos_cap) ||
                       (r_pos_cnt == CNT_W'(STACK_DEPTH));
    assign neg_full  = (CAP_W'(r_neg_cnt) >= r_neg_cap) ||
                       (r_neg_cnt == CNT_W'(STACK_DEPTH));
    assign pos_empty = (r_pos_cnt == '0);
    assign neg_empty = (r_neg_cnt == '0);

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_left    = r_left;
        n_pos_cnt = r_pos_cnt;
        n_neg_cnt = r_neg_cnt;
        pos_ctl   = '0;
        neg_ctl   = '0;
        out_load  = 1'b0;
        n_out.result_value = VAL_ZERO;
        n_out.result_kind  = KIND_DATA;
        n_out.last         = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in.cmd)
                        CMD_PUSH: begin
                            if (i_in.value[DATA_W-1]) begin
                                if (neg_full) begin
                                    out_load = 1'b1;
                                    n_out.result_value = VAL_ALL_ONES;
                                    n_out.result_kind  = KIND_FULL;
                                end else begin
                                    neg_ctl.push = 1'b1;
                                    n_neg_cnt    = r_neg_cnt + 1'b1;
                                end
                            end else begin
                                if (pos_full) begin
                                    out_load = 1'b1;
                                    n_out.result_value = VAL_ALL_ONES;
                                    n_out.result_kind  = KIND_FULL;
                                end else begin
                                    pos_ctl.push = 1'b1;
                                    n_pos_cnt    = r_pos_cnt + 1'b1;
                                end
                            end
                        end
                        CMD_POP_NEG: begin
                            out_load = 1'b1;
                            if (neg_empty) begin
                                n_out.result_kind = KIND_EMPTY;
                            end else begin
                                neg_ctl.pop = 1'b1;
                                n_neg_cnt   = r_neg_cnt - 1'b1;
                                n_out.result_value = neg_top;
                            end
                        end
                        CMD_POP_POS: begin
                            out_load = 1'b1;
                            if (pos_empty) begin
                                n_out.result_value = VAL_ALL_ONES;
                                n_out.result_kind  = KIND_EMPTY;
                            end else begin
                                pos_ctl.pop = 1'b1;
                                n_pos_cnt   = r_pos_cnt - 1'b1;
                                n_out.result_value = pos_top;
                            end
                        end
                        CMD_LIST_POS: begin
                            if (pos_empty) begin
                                out_load = 1'b1;
                                n_out.result_kind = KIND_EMPTY;
                            end else begin
                                n_state = ST_LIST;
                                n_sel   = SEL_POS;
                                n_left  = r_pos_cnt;
                            end
                        end
                        CMD_LIST_NEG: begin
                            if (neg_empty) begin
                                out_load = 1'b1;
                                n_out.result_kind = KIND_EMPTY;
                            end else begin
                                n_state = ST_LIST;
                                n_sel   = SEL_NEG;
                                n_left  = r_neg_cnt;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                            n_out.result_kind = KIND_INVALID;
                        end
                    endcase
                end
            end
            ST_LIST: begin
                // Emit the top entry and rotate it to the tail of the held
                // entries; after count rotations the stack is back in order.
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out.last = (r_left == CNT_W'(1));
                    n_left     = r_left - 1'b1;
                    if (r_sel == SEL_NEG) begin
                        neg_ctl.rot = 1'b1;
                        n_out.result_value = neg_top;
                    end else begin
                        pos_ctl.rot = 1'b1;
                        n_out.result_value = pos_top;
                    end
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= SEL_POS;
            r_left      <= '0;
            r_pos_cnt   <= '0;
            r_neg_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_left    <= n_left;
            r_pos_cnt <= n_pos_cnt;
            r_neg_cnt <= n_neg_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // The user must issue configuration writes only while the unit is idle; the unit does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_cap <= CAP_RESET;
            r_neg_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_POS_CAP) begin
                r_pos_cap <= i_cfg_data;
            end else begin
                r_neg_cap <= i_cfg_data;
            end
        end
    end

    ssds_chain #(
        .DEPTH (STACK_DEPTH)
    ) u_pos_chain (
        .i_clk       (i_clk),
        .i_ctl       (pos_ctl),
        .i_push_data (i_in.value),
        .i_count     (r_pos_cnt),
        .o_top       (pos_top)
    );

    ssds_chain #(
        .DEPTH (STACK_DEPTH)
    ) u_neg_chain (
        .i_clk       (i_clk),
        .i_ctl       (neg_ctl),
        .i_push_data (i_in.value),
        .i_count     (r_neg_cnt),
        .o_top       (neg_top)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `SSDS_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, (r_pos_cnt <= CNT_W'(STACK_DEPTH)) && (r_neg_cnt <= CNT_W'(STACK_DEPTH)))
    `SSDS_ASSERT_SAME(a_list_left, i_clk, i_rst_n, r_state == ST_LIST, r_left != '0)
    `SSDS_ASSERT_NEXT(a_pos_push, i_clk, i_rst_n, in_acc && (i_in.cmd == CMD_PUSH) && !i_in.value[DATA_W-1] && !pos_full, r_pos_cnt == $past(r_pos_cnt) + CNT_W'(1))
    `SSDS_ASSERT_NEXT(a_list_end, i_clk, i_rst_n, (r_state == ST_LIST) && out_free && (r_left == CNT_W'(1)), (r_state == ST_IDLE) && o_out_valid && o_out.last)

endmodule

// ===== src/ssds_cell.sv =====
`timescale 1ns / 1ps

module ssds_cell
    import ssds_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_prev,
    input  logic [DATA_W-1:0] i_next,
    input  logic [DATA_W-1:0] i_wrap,
    input  logic              i_is_tail,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // A push moves entries away from the top, a pop toward it. A rotation
    // moves toward the top and the tail cell catches the old top entry.
    always_comb begin
        n_data = r_data;
        if (i_ctl.push) begin
            n_data = i_prev;
        end else if (i_ctl.pop) begin
            n_data = i_next;
        end else if (i_ctl.rot) begin
            n_data = i_is_tail ? i_wrap : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== src/ssds_chain.sv =====
`timescale 1ns / 1ps

module ssds_chain
    import ssds_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                           i_clk,
    input  t_cell_ctl                      i_ctl,
    input  logic [DATA_W-1:0]              i_push_data,
    input  logic [$clog2(DEPTH+1)-1:0]     i_count,
    output logic [DATA_W-1:0]              o_top
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] w_data [DEPTH];

    // Cell 0 holds the top of the stack; cell i holds the entry i below it.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;
        logic              w_tail;

        if (i == 0) begin : g_first
            assign w_prev = i_push_data;
        end else begin : g_mid
            assign w_prev = w_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_end
            assign w_next = w_data[i];
        end else begin : g_inner
            assign w_next = w_data[i+1];
        end

        assign w_tail = (i_count == CNT_W'(i + 1));

        ssds_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .i_wrap    (w_data[0]),
            .i_is_tail (w_tail),
            .o_data    (w_data[i])
        );
    end

    assign o_top = w_data[0];

endmodule

// ===== tb/sv/tb_sign_split_dual_stack_unit.sv =====
`timescale 1ns / 1ps

module tb_sign_split_dual_stack_unit;
    import ssds_pkg::*;

    // The stack depth the unit is built with.
    localparam int DEPTH = 64;

    // Stack selectors for the testbench's own copy of the two stacks.
    localparam int POS_SIDE = 0;
    localparam int NEG_SIDE = 1;

    // Command codes 5 to 7 are reserved, and the unit must flag each one as invalid.
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    // Capacity codes of interest. Anything above the depth is clamped to the depth.
    localparam logic [CAP_W-1:0] CAP_NONE = 7'd0;
    localparam logic [CAP_W-1:0] CAP_ONE  = 7'd1;
    localparam logic [CAP_W-1:0] CAP_MAX  = 7'd127;

    // Cycles allowed, after the last result, for a push that gives no result to finish.
    localparam int SETTLE_CYCLES  = 8;
    // Length of the long receiver hold-off in the back-pressure test.
    localparam int HOLD_CYCLES    = 200;
    // The watchdog limit is several times the longest gap between two accepted
    // transactions in a correct run. The hold-off above is that longest gap.
    localparam int WATCHDOG_LIMIT = 2000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_index;
    logic [CAP_W-1:0] i_cfg_data;

    sign_split_dual_stack_unit #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The testbench keeps its own copy of both stacks and both capacities. The
    // results that each accepted command should give wait in order in
    // pending_results until the unit delivers them.
    logic [DATA_W-1:0] stack_mem [2][DEPTH];
    int unsigned       stack_fill [2];
    logic [CAP_W-1:0]  stack_cap [2];
    t_out_item         pending_results[$];

    int  fail_count;
    int  idle_cycles;
    bit  sender_gaps_on;
    bit  receiver_gaps_on;
    // The test sets this flag to ask for a long hold-off. The receiver clears it
    // when the hold-off ends.
    bit  hold_req;

    function automatic int unsigned usable_slots(logic [CAP_W-1:0] cap);
        return (cap > DEPTH) ? DEPTH : cap;
    endfunction

    function automatic void expect_result(logic [DATA_W-1:0] value,
                                          logic [KIND_W-1:0] kind, logic last);
        t_out_item r;
        r.result_value = value;
        r.result_kind  = kind;
        r.last         = last;
        pending_results.push_back(r);
    endfunction

    // Updates the stack copy for one accepted command and queues the results
    // that the command should give.
    function automatic void predict_stack_op(t_in_item item);
        int side;
        case (item.cmd)
            CMD_PUSH: begin
                // The sign bit selects the target stack, so zero goes to the positive stack.
                side = item.value[DATA_W-1] ? NEG_SIDE : POS_SIDE;
                if (stack_fill[side] >= usable_slots(stack_cap[side])) begin
                    expect_result(VAL_ALL_ONES, KIND_FULL, 1'b1);
                end else begin
                    stack_mem[side][stack_fill[side]] = item.value;
                    stack_fill[side]++;
                end
            end
            CMD_POP_POS, CMD_POP_NEG: begin
                side = (item.cmd == CMD_POP_NEG) ? NEG_SIDE : POS_SIDE;
                if (stack_fill[side] == 0) begin
                    // The two stacks report an empty pop with different values.
                    expect_result((side == POS_SIDE) ? VAL_ALL_ONES : VAL_ZERO,
                                  KIND_EMPTY, 1'b1);
                end else begin
                    stack_fill[side]--;
                    expect_result(stack_mem[side][stack_fill[side]], KIND_DATA, 1'b1);
                end
            end
            CMD_LIST_POS, CMD_LIST_NEG: begin
                side = (item.cmd == CMD_LIST_NEG) ? NEG_SIDE : POS_SIDE;
                if (stack_fill[side] == 0) begin
                    expect_result(VAL_ZERO, KIND_EMPTY, 1'b1);
                end else begin
                    for (int i = stack_fill[side]; i > 0; i--) begin
                        expect_result(stack_mem[side][i-1], KIND_DATA, i == 1);
                    end
                end
            end
            default: begin
                expect_result(VAL_ZERO, KIND_INVALID, 1'b1);
            end
        endcase
    endfunction

    function automatic t_in_item make_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
        t_in_item item;
        item.cmd   = cmd;
        item.value = value;
        return item;
    endfunction

    // A random word that is often one of the extreme values.
    function automatic logic [DATA_W-1:0] random_word();
        logic [DATA_W-1:0] w;
        w = $urandom();
        case ($urandom_range(0, 7))
            0: w = {1'b0, {(DATA_W-1){1'b1}}};
            1: w = {1'b1, {(DATA_W-1){1'b0}}};
            2: w = VAL_ZERO;
            3: w = VAL_ALL_ONES;
            default: ;
        endcase
        return w;
    endfunction

    // Random traffic leans toward pushes so that the stacks grow deep. Pops and
    // listings read the stacks back, and a few reserved commands are mixed in.
    function automatic t_in_item random_item();
        int unsigned pick;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 48) begin
            cmd = CMD_PUSH;
        end else if (pick < 64) begin
            cmd = CMD_POP_POS;
        end else if (pick < 80) begin
            cmd = CMD_POP_NEG;
        end else if (pick < 87) begin
            cmd = CMD_LIST_POS;
        end else if (pick < 94) begin
            cmd = CMD_LIST_NEG;
        end else if (pick < 96) begin
            cmd = CMD_RSVD_5;
        end else if (pick < 98) begin
            cmd = CMD_RSVD_6;
        end else begin
            cmd = CMD_RSVD_7;
        end
        return make_item(cmd, random_word());
    endfunction

    function automatic logic [CAP_W-1:0] random_capacity();
        case ($urandom_range(0, 5))
            0: return CAP_NONE;
            1: return CAP_ONE;
            2: return CAP_RESET;
            3: return CAP_MAX;
            4: return CAP_W'($urandom_range(1, DEPTH));
            default: return CAP_W'($urandom_range(0, 127));
        endcase
    endfunction

    // Sends one command transaction. Valid stays high from one transaction to
    // the next unless a gap is drawn, so it is never lowered and raised in the
    // same time step.
    task automatic send_item(input t_in_item item);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_stack_op(item);
    endtask

    // The sender pauses until every expected result has arrived. It then waits
    // out SETTLE_CYCLES so that a trailing push, which gives no result, can
    // complete.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic index, input logic [CAP_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        stack_cap[(index == CFG_POS_CAP) ? POS_SIDE : NEG_SIDE] = data;
    endtask

    // Writes both capacities back to back. Call this only once the unit is idle.
    task automatic set_capacities(input logic [CAP_W-1:0] pos_cap,
                                  input logic [CAP_W-1:0] neg_cap);
        write_capacity(CFG_POS_CAP, pos_cap);
        write_capacity(CFG_NEG_CAP, neg_cap);
        i_cfg_valid <= 1'b0;
    endtask

    // Empty pops and empty listings, the reserved commands, pushes of the
    // extreme values, and listings and pops of a few entries.
    task automatic test_empty_and_invalid();
        drain_results();
        send_item(make_item(CMD_POP_POS, VAL_ZERO));
        send_item(make_item(CMD_POP_NEG, VAL_ALL_ONES));
        send_item(make_item(CMD_LIST_POS, VAL_ZERO));
        send_item(make_item(CMD_LIST_NEG, VAL_ZERO));
        send_item(make_item(CMD_RSVD_5, VAL_ZERO));
        send_item(make_item(CMD_RSVD_6, VAL_ALL_ONES));
        send_item(make_item(CMD_RSVD_7, 32'h1234_5678));
        // Zero counts as non-negative, and each extreme sits at the edge of its stack.
        send_item(make_item(CMD_PUSH, VAL_ZERO));
        send_item(make_item(CMD_PUSH, 32'h7FFF_FFFF));
        send_item(make_item(CMD_PUSH, 32'h8000_0000));
        send_item(make_item(CMD_PUSH, VAL_ALL_ONES));
        send_item(make_item(CMD_PUSH, 32'h0000_0001));
        send_item(make_item(CMD_PUSH, 32'hFFFF_FFFE));
        send_item(make_item(CMD_LIST_POS, VAL_ZERO));
        send_item(make_item(CMD_LIST_NEG, VAL_ZERO));
        send_item(make_item(CMD_POP_POS, VAL_ZERO));
        repeat (4) send_item(make_item(CMD_POP_NEG, VAL_ZERO));
        repeat (3) send_item(make_item(CMD_POP_POS, VAL_ZERO));
    endtask

    // Small capacities, a capacity of zero, and a capacity lowered below the
    // number of entries already held.
    task automatic test_capacity_limits();
        drain_results();
        set_capacities(CAP_ONE, 7'd2);
        send_item(make_item(CMD_PUSH, 32'h0000_0011));
        send_item(make_item(CMD_PUSH, 32'h0000_0022));
        send_item(make_item(CMD_PUSH, 32'hFFFF_FF11));
        send_item(make_item(CMD_PUSH, 32'hFFFF_FF22));
        send_item(make_item(CMD_PUSH, 32'hFFFF_FF33));
        drain_results();
        // The negative stack now holds two entries against a capacity of one.
        // Pushes are refused until the count drops below the capacity.
        set_capacities(CAP_NONE, CAP_ONE);
        send_item(make_item(CMD_PUSH, 32'h0000_0033));
        send_item(make_item(CMD_PUSH, 32'hFFFF_FF44));
        send_item(make_item(CMD_POP_NEG, VAL_ZERO));
        send_item(make_item(CMD_PUSH, 32'hFFFF_FF55));
        send_item(make_item(CMD_POP_NEG, VAL_ZERO));
        send_item(make_item(CMD_PUSH, 32'hFFFF_FF66));
        send_item(make_item(CMD_POP_POS, VAL_ZERO));
        send_item(make_item(CMD_POP_POS, VAL_ZERO));
        send_item(make_item(CMD_PUSH, 32'h0000_0044));
        send_item(make_item(CMD_LIST_POS, VAL_ZERO));
        send_item(make_item(CMD_LIST_NEG, VAL_ZERO));
        send_item(make_item(CMD_POP_NEG, VAL_ZERO));
    endtask

    // Both stacks are filled to the full depth. The positive capacity is set
    // above the depth so that its clamp is exercised. Each full stack is then
    // listed, which gives the longest result burst.
    task automatic test_full_depth();
        logic [DATA_W-1:0] w;
        drain_results();
        set_capacities(CAP_MAX, CAP_RESET);
        for (int i = 0; i < DEPTH; i++) begin
            w = random_word();
            send_item(make_item(CMD_PUSH, {1'b0, w[DATA_W-2:0]}));
            w = random_word();
            send_item(make_item(CMD_PUSH, {1'b1, w[DATA_W-2:0]}));
        end
        send_item(make_item(CMD_PUSH, 32'h7FFF_FFFF));
        send_item(make_item(CMD_PUSH, 32'h8000_0000));
        send_item(make_item(CMD_LIST_POS, VAL_ZERO));
        send_item(make_item(CMD_LIST_NEG, VAL_ZERO));
        repeat (10) begin
            send_item(make_item(CMD_POP_POS, VAL_ZERO));
            send_item(make_item(CMD_POP_NEG, VAL_ZERO));
        end
    endtask

    // The receiver holds off for a long stretch while the sender offers commands
    // back to back. The output register fills, and the unit has to stall its input.
    task automatic test_backpressure();
        logic [DATA_W-1:0] w;
        drain_results();
        set_capacities(7'd8, 7'd8);
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
        hold_req         = 1'b1;
        repeat (10) begin
            w = random_word();
            send_item(make_item(CMD_PUSH, {1'b0, w[DATA_W-2:0]}));
            w = random_word();
            send_item(make_item(CMD_PUSH, {1'b1, w[DATA_W-2:0]}));
        end
        send_item(make_item(CMD_LIST_POS, VAL_ZERO));
        repeat (6) begin
            send_item(make_item(CMD_POP_NEG, VAL_ZERO));
            send_item(make_item(CMD_POP_POS, VAL_ZERO));
        end
        send_item(make_item(CMD_LIST_NEG, VAL_ZERO));
        send_item(make_item(CMD_RSVD_6, VAL_ZERO));
        drain_results();
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    // Random traffic in phases. Each phase has new capacities and a new choice
    // of whether each side idles.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            set_capacities(random_capacity(), random_capacity());
            sender_gaps_on   = 1'($urandom_range(0, 1));
            receiver_gaps_on = 1'($urandom_range(0, 1));
            repeat (30) send_item(random_item());
        end
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    // The receiver may draw a stall of random length before each result, unless
    // the test has asked for the long hold-off.
    initial begin : result_receiver
        int n;
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = receiver_gaps_on ? $urandom_range(0, 5) : 0;
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                @(posedge i_clk);
                while (!o_out_valid && !hold_req) @(posedge i_clk);
            end
        end
    end

    // Each accepted result is compared, field by field, with the oldest expectation.
    always @(posedge i_clk) begin : result_checker
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no expectation waiting: value %0d kind %0d last %0b",
                       o_out.result_value, o_out.result_kind, o_out.last);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.result_value !== want.result_value) begin
                    $error("result_value: expected %0d, actual %0d",
                           want.result_value, o_out.result_value);
                    fail_count++;
                end
                if (o_out.result_kind !== want.result_kind) begin
                    $error("result_kind: expected %0d, actual %0d",
                           want.result_kind, o_out.result_kind);
                    fail_count++;
                end
                if (o_out.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_out.last);
                    fail_count++;
                end
            end
        end
    end

    // The watchdog counts cycles in which no channel accepts a transaction. A
    // lost result or a hung unit ends the run here.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL sign_split_dual_stack_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : test_sequence
        fail_count       = 0;
        idle_cycles      = 0;
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        stack_fill[POS_SIDE] = 0;
        stack_fill[NEG_SIDE] = 0;
        stack_cap[POS_SIDE]  = CAP_RESET;
        stack_cap[NEG_SIDE]  = CAP_RESET;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_POS_CAP;
        i_cfg_data  <= CAP_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_invalid();
        test_capacity_limits();
        test_full_depth();
        test_backpressure();
        test_random_traffic();
        drain_results();

        if (fail_count == 0) begin
            $display("PASS sign_split_dual_stack_unit");
        end else begin
            $display("FAIL sign_split_dual_stack_unit");
        end
        $finish;
    end

endmodule

// ===== sign_split_dual_stack_unit.f =====
+incdir+src
src/ssds_pkg.sv
src/ssds_cell.sv
src/ssds_chain.sv
src/sign_split_dual_stack_unit.sv
tb/sv/tb_sign_split_dual_stack_unit.sv
